### hdl/ipa_pkg.sv
// ---------------------------------------------------------------------------
// ipa_pkg: shared types and constants for the IPv4 text parser
// Request structs, character classes, status codes and the classifier.
// ---------------------------------------------------------------------------
package ipa_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } ipa_in_t;

  typedef struct packed {
    logic [31:0] raw_address;
    logic [31:0] anon_address;
    logic [2:0]  status;
  } ipa_out_t;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_SPACE,
    CLS_DOT,
    CLS_BAD
  } ipa_class_t;

  // classified character as it travels through the queue
  typedef struct packed {
    ipa_class_t cls;
    logic [3:0] digit;
    logic       last;
  } ipa_tok_t;

  localparam logic [2:0] ST_OK                = 3'd0;
  localparam logic [2:0] ST_DIGIT_AFTER_SPACE = 3'd1;
  localparam logic [2:0] ST_DOT_AFTER_SPACE   = 3'd2;
  localparam logic [2:0] ST_DOUBLE_DOT        = 3'd3;
  localparam logic [2:0] ST_TOO_MANY_DOTS     = 3'd4;
  localparam logic [2:0] ST_BAD_CHAR          = 3'd5;
  localparam logic [2:0] ST_DOT_COUNT         = 3'd6;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [1:0] LAST_DOT   = 2'd3;
  localparam logic [5:0] ANON_RESET = 6'd16;

  function automatic ipa_tok_t ipa_classify(input ipa_in_t req);
    ipa_tok_t   tok;
    logic [7:0] offs;
    offs      = req.char_code - CHAR_ZERO;
    tok.last  = req.last_char;
    tok.digit = offs[3:0];
    if (req.char_code >= CHAR_ZERO && req.char_code <= CHAR_NINE) begin
      tok.cls = CLS_DIGIT;
    end else if (req.char_code == CHAR_SPACE) begin
      tok.cls = CLS_SPACE;
    end else if (req.char_code == CHAR_DOT) begin
      tok.cls = CLS_DOT;
    end else begin
      tok.cls = CLS_BAD;
    end
    return tok;
  endfunction

endpackage

### hdl/ipa_front.sv
// ---------------------------------------------------------------------------
// ipa_front: input stage
// Accepts characters, classifies them and holds one token for the queue.
// ---------------------------------------------------------------------------
module ipa_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ipa_pkg::ipa_in_t in_data,
  output logic             tok_valid,
  output ipa_pkg::ipa_tok_t tok,
  input  logic             q_full
);
  import ipa_pkg::*;

  logic     hold_valid;
  logic     hold_valid_next;
  ipa_tok_t hold_tok;
  logic     accept;

  assign in_stall  = hold_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign tok_valid = hold_valid;
  assign tok       = hold_tok;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (hold_valid && !q_full) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_tok <= ipa_classify(in_data);
    end
  end

endmodule

### hdl/ipa_queue.sv
// ---------------------------------------------------------------------------
// ipa_queue: token queue
// Short FIFO between the classifier and the parse engine.
// ---------------------------------------------------------------------------
module ipa_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  ipa_pkg::ipa_tok_t push_tok,
  output logic              full,
  output logic              pop_valid,
  output ipa_pkg::ipa_tok_t pop_tok,
  input  logic              pop
);
  import ipa_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  ipa_tok_t      slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_tok   = slots[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

endmodule

### hdl/ipa_back.sv
// ---------------------------------------------------------------------------
// ipa_back: parse engine
// Updates octets and flags per token, then assembles and masks the address.
// ---------------------------------------------------------------------------
module ipa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  ipa_pkg::ipa_tok_t  tok,
  output logic               tok_pop,
  input  logic [5:0]         anon_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output ipa_pkg::ipa_out_t  out_data
);
  import ipa_pkg::*;

  // parse state
  logic [31:0] acc [4];
  logic [1:0]  dot_cnt;
  logic        prev_dot;
  logic        lead_blank;
  logic        trail_blank;
  logic        first_char;
  logic [2:0]  err;

  logic [31:0] acc_next [4];
  logic [1:0]  dot_cnt_next;
  logic        prev_dot_next;
  logic        lead_blank_next;
  logic        trail_blank_next;
  logic [2:0]  err_next;
  logic [2:0]  fin_err_next;
  logic [31:0] acc_mul;

  // finished address, waiting for assembly
  logic        fin_valid;
  logic [31:0] fin_oct [4];
  logic [2:0]  fin_err;

  logic        out_adv;
  logic        fin_free;
  logic [31:0] raw_sum;
  logic [31:0] raw;
  logic [31:0] keep_mask;

  assign out_adv  = !out_valid || !out_stall;
  assign fin_free = !fin_valid || out_adv;
  assign tok_pop  = tok_valid && (!tok.last || fin_free);

  // acc * 10 + digit, wraps mod 2^32
  assign acc_mul = (acc[dot_cnt] << 3) + (acc[dot_cnt] << 1) + {28'd0, tok.digit};

  always_comb begin
    acc_next         = acc;
    dot_cnt_next     = dot_cnt;
    prev_dot_next    = prev_dot;
    lead_blank_next  = lead_blank;
    trail_blank_next = trail_blank;
    err_next         = err;
    if (err == ST_OK) begin
      case (tok.cls)
        CLS_DIGIT: begin
          if (trail_blank) begin
            err_next = ST_DIGIT_AFTER_SPACE;
          end else begin
            prev_dot_next     = 1'b0;
            lead_blank_next   = 1'b0;
            acc_next[dot_cnt] = acc_mul;
          end
        end
        CLS_SPACE: begin
          prev_dot_next = 1'b0;
          if (first_char || lead_blank) begin
            lead_blank_next = 1'b1;
          end else begin
            trail_blank_next = 1'b1;
          end
        end
        CLS_DOT: begin
          if (trail_blank) begin
            err_next = ST_DOT_AFTER_SPACE;
          end else begin
            lead_blank_next = 1'b0;
            if (prev_dot) begin
              err_next = ST_DOUBLE_DOT;
            end else begin
              prev_dot_next = 1'b1;
              if (dot_cnt == LAST_DOT) begin
                err_next = ST_TOO_MANY_DOTS;
              end else begin
                dot_cnt_next = dot_cnt + 1'b1;
              end
            end
          end
        end
        default: begin
          err_next = ST_BAD_CHAR;
        end
      endcase
    end
    fin_err_next = err_next;
    if (err_next == ST_OK && dot_cnt_next != LAST_DOT) begin
      fin_err_next = ST_DOT_COUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        acc[i] <= '0;
      end
      dot_cnt     <= '0;
      prev_dot    <= 1'b0;
      lead_blank  <= 1'b0;
      trail_blank <= 1'b0;
      first_char  <= 1'b1;
      err         <= ST_OK;
    end else if (tok_pop) begin
      if (tok.last) begin
        for (int i = 0; i < 4; i++) begin
          acc[i] <= '0;
        end
        dot_cnt     <= '0;
        prev_dot    <= 1'b0;
        lead_blank  <= 1'b0;
        trail_blank <= 1'b0;
        first_char  <= 1'b1;
        err         <= ST_OK;
      end else begin
        acc         <= acc_next;
        dot_cnt     <= dot_cnt_next;
        prev_dot    <= prev_dot_next;
        lead_blank  <= lead_blank_next;
        trail_blank <= trail_blank_next;
        first_char  <= 1'b0;
        err         <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (tok_pop && tok.last) begin
      fin_valid <= 1'b1;
    end else if (out_adv) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.last) begin
      fin_oct <= acc_next;
      fin_err <= fin_err_next;
    end
  end

  // assembly and masking
  assign raw_sum   = (fin_oct[0] << 24) + (fin_oct[1] << 16) + (fin_oct[2] << 8) + fin_oct[3];
  assign raw       = (fin_err != ST_OK) ? '1 : raw_sum;
  assign keep_mask = anon_bits[5] ? '0 : ('1 << anon_bits[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && fin_valid) begin
      out_data.raw_address  <= raw;
      out_data.anon_address <= raw & keep_mask;
      out_data.status       <= fin_err;
    end
  end

endmodule

### hdl/ipv4_text_parse_anonymize_core.sv
// ---------------------------------------------------------------------------
// ipv4_text_parse_anonymize_core: dotted-decimal IPv4 parser and anonymizer
// Path: a last character passes the front hold, a queue slot, the finish
//   stage and the output register, in that order, before out_valid rises.
// Throughput: one character per cycle while the output is not stalled; the
//   parse engine retires one token a cycle. Under output stalls a last
//   character waits while the finish stage and output register are both
//   held, and a full queue takes no push in the cycle it pops.
// Reset: rst (synchronous) empties the pipeline, clears parse state and sets
//   anon_bits to 16. No clearing pass.
// ---------------------------------------------------------------------------
module ipv4_text_parse_anonymize_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ipa_pkg::ipa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ipa_pkg::ipa_out_t out_data,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_data
);
  import ipa_pkg::*;

  // anonymizer width register; the user must write it only while idle, the block itself does not enforce this
  logic [5:0] anon_bits;

  // front -> queue
  logic     f_valid;
  ipa_tok_t f_tok;
  logic     q_full;

  // queue -> back
  logic     q_valid;
  ipa_tok_t q_tok;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      anon_bits <= ANON_RESET;
    end else if (cfg_we) begin
      anon_bits <= cfg_data;
    end
  end

  // Front: take a character request, classify it (digit/space/dot/other)
  // and hold the token until the queue has room.
  ipa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .tok_valid (f_valid),
    .tok       (f_tok),
    .q_full    (q_full)
  );

  // Queue decouples input stalls from output stalls.
  ipa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_tok   (f_tok),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_tok    (q_tok),
    .pop        (q_pop)
  );

  // Back: per-token octet/flag update; on the last token the final octets
  // go to an assembly stage, then sum + mask into the output register.
  // Non-last tokens drain even while the output is stalled.
  ipa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok       (q_tok),
    .tok_pop   (q_pop),
    .anon_bits (anon_bits),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // any error forces the raw address to all ones
  a_err_all_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.raw_address == '1)
    else $error("error result without all-ones address");

  // anonymized address only ever clears bits of the raw address
  a_anon_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.anon_address & ~out_data.raw_address) == '0)
    else $error("anon address sets bits not in raw address");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_DOT_COUNT)
    else $error("status code out of range");

endmodule
